>>> rtl/core/php_pkg.sv
// Types and constants shared by the PES header parser modules.
package php_pkg;

  typedef struct packed {
    logic [7:0]  hdr_byte;
    logic        header_start;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [32:0] pts;
    logic        pts_valid;
    logic [32:0] dts;
    logic        dts_valid;
    logic [7:0]  substream;
    logic [15:0] payload_length;
    logic        bad_header;
    logic        is_mpeg2;
  } out_item_t;

  // Input item with byte classes worked out ahead of the parser.
  typedef struct packed {
    in_item_t item;
    logic     is_stuff;
    logic     is_m2_form;
    logic     is_m1_std;
    logic     is_ac3;
    logic     is_pcm;
    logic     is_subt;
  } cls_item_t;

  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [7:0] SUB_NONE   = 8'hFF;
  localparam logic [7:0] SUBT_LAST  = 8'h26;
  localparam logic [7:0] AC3_FIRST  = 8'h80;
  localparam logic [7:0] AC3_LAST   = 8'h87;
  localparam logic [7:0] PCM_FIRST  = 8'hA0;
  localparam logic [7:0] PCM_LAST   = 8'hA7;
  localparam logic [7:0] SUBT_FIRST = 8'h20;
  localparam logic [7:0] SUBT_END   = 8'h27;

  localparam logic [1:0] M2_FORM_TAG = 2'b10;
  localparam logic [1:0] M1_STD_TAG  = 2'b01;

  localparam logic [1:0] TS_CODE_BAD  = 2'b01;
  localparam logic [1:0] TS_CODE_PTS  = 2'b10;
  localparam logic [1:0] TS_CODE_BOTH = 2'b11;

  localparam logic [3:0] M1_CODE_BAD  = 4'h1;
  localparam logic [3:0] M1_CODE_PTS  = 4'h2;
  localparam logic [3:0] M1_CODE_BOTH = 4'h3;

  localparam logic [7:0] TS_PTS_LEN  = 8'd5;
  localparam logic [7:0] TS_BOTH_LEN = 8'd10;
  localparam logic [7:0] AUDIO_SKIP  = 8'd3;
  localparam logic [7:0] PCM_SKIP    = 8'd6;

endpackage

>>> rtl/core/pes_header_parser_core.sv
// Top level of the PES header parser: front queue and parser back end.
//
//  channel   direction  handshake           payload
//  in_*      input      push / full         in_item  (php_pkg::in_item_t)
//  out_*     output     empty / pop         out_item (php_pkg::out_item_t)
//
// One header byte per clock sustained; a byte reaches the parser the cycle after push.
// A result shows on out_item the cycle after its last header byte is parsed.
// The single result register sets the pace: while it waits for pop, the parser holds
// and up to QUEUE_DEPTH bytes gather in the front queue before full rises.
// Synchronous active-low reset empties the queue and the result register.
module pes_header_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  php_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output php_pkg::out_item_t out_item
);

  logic               q_valid;
  logic               q_pop;
  php_pkg::cls_item_t q_item;

  php_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  php_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

>>> rtl/core/php_front.sv
// Front end: accepts header bytes, classifies them and queues them for the parser.
module php_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  php_pkg::in_item_t  in_item,
  output logic               q_valid,
  input  logic               q_pop,
  output php_pkg::cls_item_t q_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  php_pkg::cls_item_t mem_r [QUEUE_DEPTH];
  php_pkg::cls_item_t cls;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  always_comb begin
    cls.item       = in_item;
    cls.is_stuff   = (in_item.hdr_byte == php_pkg::STUFF_BYTE);
    cls.is_m2_form = (in_item.hdr_byte[7:6] == php_pkg::M2_FORM_TAG);
    cls.is_m1_std  = (in_item.hdr_byte[7:6] == php_pkg::M1_STD_TAG);
    cls.is_ac3     = in_item.hdr_byte inside {[php_pkg::AC3_FIRST:php_pkg::AC3_LAST]};
    cls.is_pcm     = in_item.hdr_byte inside {[php_pkg::PCM_FIRST:php_pkg::PCM_LAST]};
    cls.is_subt    = in_item.hdr_byte inside {[php_pkg::SUBT_FIRST:php_pkg::SUBT_END]};
  end

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ((wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

>>> rtl/core/php_back.sv
// Back end: header parser state machine with a one-entry result register.
module php_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  php_pkg::cls_item_t q_item,
  output logic               empty,
  input  logic               pop,
  output php_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_STUFF, PH_M2_FLAGS, PH_M2_LEN, PH_M2_TS, PH_M2_HSKIP,
    PH_M2_SUB, PH_M2_ASKIP, PH_M1_STD, PH_M1_C, PH_M1_PTS, PH_M1_DSKIP
  } phase_t;

  function automatic logic [15:0] sat_sub(logic [15:0] a, logic [15:0] n);
    return (a > n) ? (a - n) : 16'd0;
  endfunction

  function automatic logic [32:0] ts_part(logic [3:0] idx, logic [7:0] b);
    logic [32:0] v;
    v = {25'd0, b};
    case (idx)
      4'd0:    return {v[3:1], 30'd0};
      4'd1:    return v << 22;
      4'd2:    return (v >> 1) << 15;
      4'd3:    return v << 7;
      default: return v >> 1;
    endcase
  endfunction

  phase_t      phase_r, phase_nxt, c_phase;
  logic [15:0] bl_r, bl_nxt, c_bl;
  logic [7:0]  skip_r, skip_nxt, c_skip;
  logic [3:0]  fi_r, fi_nxt, c_fi;
  logic [7:0]  flags_r, flags_nxt, c_flags;
  logic [32:0] pts_r, pts_nxt, c_pts;
  logic [32:0] dts_r, dts_nxt, c_dts;
  logic [7:0]  sub_r, sub_nxt, c_sub;
  logic        pok_r, pok_nxt, c_pok;
  logic        dok_r, dok_nxt, c_dok;
  logic        m2_r, m2_nxt, c_m2;

  logic               out_valid_r;
  php_pkg::out_item_t out_data_r;
  php_pkg::out_item_t res;
  logic               go, out_take, emit, bad;
  logic               do_m1flags, do_after_ts, do_after_skip;
  logic [7:0]         b, id, extra;
  logic [3:0]         m1_code;

  assign out_take = pop && out_valid_r;
  assign go       = q_valid && (!out_valid_r || out_take);
  assign q_pop    = go;
  assign empty    = !out_valid_r;
  assign out_item = out_data_r;
  assign b        = q_item.item.hdr_byte;
  assign m1_code  = b[7:4];

  always_comb begin
    if (q_item.item.header_start) begin
      c_phase = PH_STUFF;
      c_bl    = q_item.item.packet_length;
      c_skip  = '0;
      c_fi    = '0;
      c_flags = '0;
      c_pts   = '0;
      c_dts   = '0;
      c_sub   = php_pkg::SUB_NONE;
      c_pok   = 1'b0;
      c_dok   = 1'b0;
      c_m2    = 1'b0;
    end else begin
      c_phase = phase_r;
      c_bl    = bl_r;
      c_skip  = skip_r;
      c_fi    = fi_r;
      c_flags = flags_r;
      c_pts   = pts_r;
      c_dts   = dts_r;
      c_sub   = sub_r;
      c_pok   = pok_r;
      c_dok   = dok_r;
      c_m2    = m2_r;
    end

    phase_nxt     = c_phase;
    bl_nxt        = c_bl;
    skip_nxt      = c_skip;
    fi_nxt        = c_fi;
    flags_nxt     = c_flags;
    pts_nxt       = c_pts;
    dts_nxt       = c_dts;
    sub_nxt       = c_sub;
    pok_nxt       = c_pok;
    dok_nxt       = c_dok;
    m2_nxt        = c_m2;
    emit          = 1'b0;
    bad           = 1'b0;
    do_m1flags    = 1'b0;
    do_after_ts   = 1'b0;
    do_after_skip = 1'b0;
    id            = b;
    extra         = '0;

    case (c_phase)
      PH_IDLE: begin
      end
      PH_STUFF: begin
        if (q_item.is_stuff) begin
          bl_nxt = sat_sub(c_bl, 16'd1);
        end else if (q_item.is_m2_form) begin
          m2_nxt    = 1'b1;
          phase_nxt = PH_M2_FLAGS;
        end else if (q_item.is_m1_std) begin
          bl_nxt    = sat_sub(c_bl, 16'd2);
          phase_nxt = PH_M1_STD;
        end else begin
          do_m1flags = 1'b1;
        end
      end
      PH_M2_FLAGS: begin
        flags_nxt = b;
        phase_nxt = PH_M2_LEN;
      end
      PH_M2_LEN: begin
        fi_nxt = '0;
        if (c_flags[7:6] == php_pkg::TS_CODE_BAD) begin
          bl_nxt = sat_sub(c_bl, 16'd3);
          emit   = 1'b1;
          bad    = 1'b1;
        end else if (c_flags[7:6] == php_pkg::TS_CODE_PTS && b >= php_pkg::TS_PTS_LEN) begin
          skip_nxt  = b - php_pkg::TS_PTS_LEN;
          bl_nxt    = sat_sub(c_bl, 16'd8);
          phase_nxt = PH_M2_TS;
        end else if (c_flags[7:6] == php_pkg::TS_CODE_BOTH && b >= php_pkg::TS_BOTH_LEN) begin
          skip_nxt  = b - php_pkg::TS_BOTH_LEN;
          bl_nxt    = sat_sub(c_bl, 16'd13);
          phase_nxt = PH_M2_TS;
        end else begin
          skip_nxt    = b;
          bl_nxt      = sat_sub(c_bl, 16'd3);
          do_after_ts = 1'b1;
        end
      end
      PH_M2_TS: begin
        if (c_fi < 4'd5) begin
          pts_nxt = c_pts | ts_part(c_fi, b);
        end else begin
          dts_nxt = c_dts | ts_part(c_fi - 4'd5, b);
        end
        fi_nxt = c_fi + 4'd1;
        if (fi_nxt == 4'd5) begin
          pok_nxt = 1'b1;
        end
        if (fi_nxt == 4'd10) begin
          dok_nxt = 1'b1;
        end
        if ((fi_nxt == 4'd5 && c_flags[7:6] == php_pkg::TS_CODE_PTS) || fi_nxt >= 4'd10) begin
          do_after_ts = 1'b1;
        end
      end
      PH_M2_HSKIP: begin
        skip_nxt = c_skip - 8'd1;
        if (skip_nxt == '0) begin
          do_after_skip = 1'b1;
        end
      end
      PH_M2_SUB: begin
        if (q_item.is_ac3) begin
          id    = {5'd0, b[2:0]};
          extra = php_pkg::AUDIO_SKIP;
        end else if (q_item.is_pcm) begin
          extra = php_pkg::PCM_SKIP;
        end else if (q_item.is_subt) begin
          extra = (b > php_pkg::SUBT_LAST) ? php_pkg::AUDIO_SKIP : 8'd0;
        end else begin
          id    = php_pkg::SUB_NONE;
          extra = php_pkg::AUDIO_SKIP;
        end
        sub_nxt = id;
        bl_nxt  = sat_sub(c_bl, {8'd0, extra} + 16'd1);
        if (extra != '0) begin
          skip_nxt  = extra;
          phase_nxt = PH_M2_ASKIP;
        end else begin
          emit = 1'b1;
        end
      end
      PH_M2_ASKIP, PH_M1_DSKIP: begin
        skip_nxt = c_skip - 8'd1;
        if (skip_nxt == '0) begin
          emit = 1'b1;
        end
      end
      PH_M1_STD: begin
        phase_nxt = PH_M1_C;
      end
      PH_M1_C: begin
        do_m1flags = 1'b1;
      end
      PH_M1_PTS: begin
        pts_nxt = c_pts | ts_part(c_fi, b);
        fi_nxt  = c_fi + 4'd1;
        if (fi_nxt >= 4'd5) begin
          pok_nxt = 1'b1;
          if (c_flags[7:4] == php_pkg::M1_CODE_BOTH) begin
            skip_nxt  = 8'd5;
            phase_nxt = PH_M1_DSKIP;
          end else begin
            emit = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (do_m1flags) begin
      flags_nxt = b;
      if (m1_code == php_pkg::M1_CODE_BAD) begin
        bl_nxt = sat_sub(c_bl, 16'd1);
        emit   = 1'b1;
        bad    = 1'b1;
      end else if (m1_code == php_pkg::M1_CODE_PTS || m1_code == php_pkg::M1_CODE_BOTH) begin
        bl_nxt    = sat_sub(c_bl, (m1_code == php_pkg::M1_CODE_PTS) ? 16'd5 : 16'd10);
        pts_nxt   = ts_part(4'd0, b);
        fi_nxt    = 4'd1;
        phase_nxt = PH_M1_PTS;
      end else begin
        bl_nxt = sat_sub(c_bl, 16'd1);
        emit   = 1'b1;
      end
    end

    if (do_after_ts) begin
      if (skip_nxt != '0) begin
        bl_nxt    = sat_sub(bl_nxt, {8'd0, skip_nxt});
        phase_nxt = PH_M2_HSKIP;
      end else begin
        do_after_skip = 1'b1;
      end
    end

    if (do_after_skip) begin
      if (bl_nxt > 16'd5) begin
        phase_nxt = PH_M2_SUB;
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
    end

    res.pts            = (!bad && pok_nxt) ? pts_nxt : '0;
    res.pts_valid      = !bad && pok_nxt;
    res.dts            = (!bad && dok_nxt) ? dts_nxt : '0;
    res.dts_valid      = !bad && dok_nxt;
    res.substream      = bad ? php_pkg::SUB_NONE : sub_nxt;
    res.payload_length = bad ? 16'd0 : bl_nxt;
    res.bad_header     = bad;
    res.is_mpeg2       = m2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bl_r        <= '0;
      skip_r      <= '0;
      fi_r        <= '0;
      flags_r     <= '0;
      pts_r       <= '0;
      dts_r       <= '0;
      sub_r       <= php_pkg::SUB_NONE;
      pok_r       <= 1'b0;
      dok_r       <= 1'b0;
      m2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        bl_r    <= bl_nxt;
        skip_r  <= skip_nxt;
        fi_r    <= fi_nxt;
        flags_r <= flags_nxt;
        pts_r   <= pts_nxt;
        dts_r   <= dts_nxt;
        sub_r   <= sub_nxt;
        pok_r   <= pok_nxt;
        dok_r   <= dok_nxt;
        m2_r    <= m2_nxt;
      end
      if (go && emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pop |=> out_valid_r && $stable(out_data_r))
    else $error("waiting result lost or changed");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bad_header |->
      !out_data_r.pts_valid && !out_data_r.dts_valid && out_data_r.payload_length == 16'd0)
    else $error("bad header result carries stamps or length");

  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    go && !q_item.item.header_start && phase_r == PH_IDLE |=> phase_r == PH_IDLE && !$rose(out_valid_r))
    else $error("idle byte started a parse or gave a result");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pop |-> !q_pop)
    else $error("parser advanced while result register blocked");

endmodule

>>> sim/tb_pes_header_parser_core.sv
// Testbench for pes_header_parser_core: directed and random header bytes checked by a predictor.
module tb_pes_header_parser_core;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STUFF, ST_M2_FLAGS, ST_M2_LEN, ST_M2_TS, ST_M2_HSKIP, ST_M2_SUB,
    ST_M2_ASKIP, ST_M1_STD, ST_M1_C, ST_M1_PTS, ST_M1_DSKIP
  } parse_phase_t;

  typedef struct {
    php_pkg::in_item_t  item;
    bit                 typed;
    php_pkg::out_item_t want;
  } stim_row_t;

  localparam logic [1:0] TS_CODE_NONE = 2'b00;
  localparam logic [3:0] M1_CODE_NONE = 4'h0;

  localparam php_pkg::out_item_t M2_BAD_RES = '{pts: '0, pts_valid: 1'b0, dts: '0,
    dts_valid: 1'b0, substream: php_pkg::SUB_NONE, payload_length: '0, bad_header: 1'b1,
    is_mpeg2: 1'b1};
  localparam php_pkg::out_item_t M1_BAD_RES = '{pts: '0, pts_valid: 1'b0, dts: '0,
    dts_valid: 1'b0, substream: php_pkg::SUB_NONE, payload_length: '0, bad_header: 1'b1,
    is_mpeg2: 1'b0};
  localparam php_pkg::out_item_t M1_NONE_RES = '{pts: '0, pts_valid: 1'b0, dts: '0,
    dts_valid: 1'b0, substream: php_pkg::SUB_NONE, payload_length: '0, bad_header: 1'b0,
    is_mpeg2: 1'b0};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  php_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  php_pkg::out_item_t out_item;

  // predictor state
  parse_phase_t       cur_phase;
  logic [16:0]        left_cnt;
  logic [7:0]         skip_cnt;
  logic [3:0]         ts_idx;
  logic [7:0]         flags_q;
  logic               align_q;
  logic [32:0]        pts_q;
  logic [32:0]        dts_q;
  logic [7:0]         sub_q;
  logic               pts_seen;
  logic               dts_seen;
  logic               m2_seen;
  bit                 res_ready;
  php_pkg::out_item_t res_val;

  php_pkg::out_item_t pending_hdrs[$];
  stim_row_t          dir_rows[$];
  int                 errors = 0;
  int                 live_items = 0;
  bit                 quiet_in = 1'b0;
  bit                 quiet_out = 1'b0;

  pes_header_parser_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  function automatic void clear_parse();
    cur_phase = ST_IDLE;
    left_cnt  = '0;
    skip_cnt  = '0;
    ts_idx    = '0;
    flags_q   = '0;
    align_q   = 1'b0;
    pts_q     = '0;
    dts_q     = '0;
    sub_q     = php_pkg::SUB_NONE;
    pts_seen  = 1'b0;
    dts_seen  = 1'b0;
    m2_seen   = 1'b0;
  endfunction

  function automatic void take_len(int unsigned n);
    left_cnt = (left_cnt > n) ? 17'(left_cnt - n) : '0;
  endfunction

  function automatic logic [32:0] ts_bits(logic [3:0] idx, logic [7:0] b);
    case (idx)
      4'd0: return {b[3:1], 30'd0};
      4'd1: return {3'd0, b, 22'd0};
      4'd2: return {11'd0, b[7:1], 15'd0};
      4'd3: return {18'd0, b, 7'd0};
      default: return {26'd0, b[7:1]};
    endcase
  endfunction

  function automatic void close_hdr(bit bad);
    res_val.pts            = (!bad && pts_seen) ? pts_q : '0;
    res_val.pts_valid      = bad ? 1'b0 : pts_seen;
    res_val.dts            = (!bad && dts_seen) ? dts_q : '0;
    res_val.dts_valid      = bad ? 1'b0 : dts_seen;
    res_val.substream      = bad ? php_pkg::SUB_NONE : sub_q;
    res_val.payload_length = bad ? '0 : left_cnt[15:0];
    res_val.bad_header     = bad;
    res_val.is_mpeg2       = m2_seen;
    res_ready = 1'b1;
    cur_phase = ST_IDLE;
  endfunction

  function automatic void try_substream();
    if (left_cnt > 5) begin
      cur_phase = ST_M2_SUB;
    end else begin
      close_hdr(1'b0);
    end
  endfunction

  function automatic void skip_hdr_rest();
    if (skip_cnt != 0) begin
      take_len(skip_cnt);
      cur_phase = ST_M2_HSKIP;
    end else begin
      try_substream();
    end
  endfunction

  function automatic void m1_flags(logic [7:0] c);
    flags_q = c;
    take_len(1);
    if (c[7:4] == php_pkg::M1_CODE_BAD) begin
      close_hdr(1'b1);
    end else if (c[7:4] == php_pkg::M1_CODE_PTS || c[7:4] == php_pkg::M1_CODE_BOTH) begin
      take_len(c[7:4] == php_pkg::M1_CODE_PTS ? php_pkg::TS_PTS_LEN - 1
                                               : php_pkg::TS_BOTH_LEN - 1);
      pts_q = ts_bits(4'd0, c);
      ts_idx = 4'd1;
      cur_phase = ST_M1_PTS;
    end else begin
      close_hdr(1'b0);
    end
  endfunction

  function automatic void parse_hdr_byte(php_pkg::in_item_t it);
    logic [7:0] b;
    logic [1:0] code;
    logic [7:0] id;
    logic [7:0] extra;
    b = it.hdr_byte;
    res_ready = 1'b0;
    if (it.header_start) begin
      clear_parse();
      left_cnt = {1'b0, it.packet_length};
      cur_phase = ST_STUFF;
    end else if (cur_phase == ST_IDLE) begin
      return;
    end
    case (cur_phase)
      ST_STUFF: begin
        if (b == php_pkg::STUFF_BYTE) begin
          take_len(1);
        end else if (b[7:6] == php_pkg::M2_FORM_TAG) begin
          m2_seen = 1'b1;
          align_q = b[2];
          cur_phase = ST_M2_FLAGS;
        end else if (b[7:6] == php_pkg::M1_STD_TAG) begin
          take_len(2);
          cur_phase = ST_M1_STD;
        end else begin
          m1_flags(b);
        end
      end
      ST_M2_FLAGS: begin
        flags_q = b;
        cur_phase = ST_M2_LEN;
      end
      ST_M2_LEN: begin
        take_len(3);
        code = flags_q[7:6];
        if (code == php_pkg::TS_CODE_BAD) begin
          close_hdr(1'b1);
        end else begin
          ts_idx = '0;
          if (code == php_pkg::TS_CODE_PTS && b >= php_pkg::TS_PTS_LEN) begin
            skip_cnt = b - php_pkg::TS_PTS_LEN;
            take_len(php_pkg::TS_PTS_LEN);
            cur_phase = ST_M2_TS;
          end else if (code == php_pkg::TS_CODE_BOTH && b >= php_pkg::TS_BOTH_LEN) begin
            skip_cnt = b - php_pkg::TS_BOTH_LEN;
            take_len(php_pkg::TS_BOTH_LEN);
            cur_phase = ST_M2_TS;
          end else begin
            skip_cnt = b;
            skip_hdr_rest();
          end
        end
      end
      ST_M2_TS: begin
        if (ts_idx < 5) begin
          pts_q |= ts_bits(ts_idx, b);
        end else begin
          dts_q |= ts_bits(ts_idx - 4'd5, b);
        end
        ts_idx = ts_idx + 4'd1;
        if (ts_idx == 5) pts_seen = 1'b1;
        if (ts_idx == 10) dts_seen = 1'b1;
        if ((ts_idx == 5 && flags_q[7:6] == php_pkg::TS_CODE_PTS) || ts_idx >= 10) begin
          skip_hdr_rest();
        end
      end
      ST_M2_HSKIP: begin
        skip_cnt = skip_cnt - 8'd1;
        if (skip_cnt == 0) try_substream();
      end
      ST_M2_SUB: begin
        id = b;
        extra = '0;
        if (b >= php_pkg::AC3_FIRST && b <= php_pkg::AC3_LAST) begin
          id = b - php_pkg::AC3_FIRST;
        end else if (b >= php_pkg::PCM_FIRST && b <= php_pkg::PCM_LAST) begin
          extra = php_pkg::AUDIO_SKIP;
        end else if (!(b >= php_pkg::SUBT_FIRST && b <= php_pkg::SUBT_END)) begin
          id = php_pkg::SUB_NONE;
        end
        if (id > php_pkg::SUBT_LAST || id < php_pkg::SUBT_FIRST) begin
          extra = extra + php_pkg::AUDIO_SKIP;
        end
        sub_q = id;
        take_len(1 + extra);
        if (extra != 0) begin
          skip_cnt = extra;
          cur_phase = ST_M2_ASKIP;
        end else begin
          close_hdr(1'b0);
        end
      end
      ST_M2_ASKIP, ST_M1_DSKIP: begin
        skip_cnt = skip_cnt - 8'd1;
        if (skip_cnt == 0) close_hdr(1'b0);
      end
      ST_M1_STD: begin
        cur_phase = ST_M1_C;
      end
      ST_M1_C: begin
        m1_flags(b);
      end
      ST_M1_PTS: begin
        pts_q |= ts_bits(ts_idx, b);
        ts_idx = ts_idx + 4'd1;
        if (ts_idx >= 5) begin
          pts_seen = 1'b1;
          if (flags_q[7:4] == php_pkg::M1_CODE_BOTH) begin
            skip_cnt = php_pkg::TS_PTS_LEN;
            cur_phase = ST_M1_DSKIP;
          end else begin
            close_hdr(1'b0);
          end
        end
      end
      default: begin
        cur_phase = ST_IDLE;
      end
    endcase
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] m1_flag_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: b[7:4] = php_pkg::M1_CODE_BAD;
      1: b[7:4] = php_pkg::M1_CODE_PTS;
      2: b[7:4] = php_pkg::M1_CODE_BOTH;
      3: b[7:4] = M1_CODE_NONE;
      default: ;
    endcase
    return b;
  endfunction

  // pick a plausible next byte for the given parse phase
  function automatic logic [7:0] byte_for(parse_phase_t ph);
    int r;
    logic [7:0] b;
    logic [7:0] base;
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    case (ph)
      ST_STUFF: begin
        if (r < 20) b = php_pkg::STUFF_BYTE;
        else if (r < 60) b[7:6] = php_pkg::M2_FORM_TAG;
        else if (r < 75) b[7:6] = php_pkg::M1_STD_TAG;
        else b = m1_flag_byte();
      end
      ST_M1_C: begin
        b = m1_flag_byte();
      end
      ST_M2_FLAGS: begin
        if (r < 40) b[7:6] = php_pkg::TS_CODE_BOTH;
        else if (r < 75) b[7:6] = php_pkg::TS_CODE_PTS;
        else if (r < 88) b[7:6] = TS_CODE_NONE;
        else b[7:6] = php_pkg::TS_CODE_BAD;
      end
      ST_M2_LEN: begin
        case (flags_q[7:6])
          php_pkg::TS_CODE_PTS: base = php_pkg::TS_PTS_LEN;
          php_pkg::TS_CODE_BOTH: base = php_pkg::TS_BOTH_LEN;
          default: base = '0;
        endcase
        if (r < 75) b = base + 8'($urandom_range(0, 3));
        else if (r < 98) b = 8'($urandom_range(0, 12));
      end
      ST_M2_SUB: begin
        if (r < 30) b = php_pkg::AC3_FIRST + 8'($urandom_range(0, 7));
        else if (r < 55) b = php_pkg::PCM_FIRST + 8'($urandom_range(0, 7));
        else if (r < 80) b = php_pkg::SUBT_FIRST + 8'($urandom_range(0, 7));
      end
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 40));
    if (r < 75) return 16'($urandom_range(0, 300));
    if (r < 88) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void add_row(logic [7:0] b, logic st, logic [15:0] len, bit typed,
                                  php_pkg::out_item_t want);
    stim_row_t r;
    r.item.hdr_byte      = b;
    r.item.header_start  = st;
    r.item.packet_length = len;
    r.typed              = typed;
    r.want               = want;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(php_pkg::in_item_t it, bit typed, php_pkg::out_item_t want);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full !== 1'b0);
    if (it.header_start || cur_phase != ST_IDLE) live_items++;
    parse_hdr_byte(it);
    if (typed) begin
      pending_hdrs.push_back(want);
    end else if (res_ready) begin
      pending_hdrs.push_back(res_val);
    end
    @(negedge clk);
  endtask

  task automatic send_data(logic [7:0] b);
    php_pkg::in_item_t it;
    it.hdr_byte      = b;
    it.header_start  = 1'b0;
    it.packet_length = 16'($urandom_range(0, 65535));
    send_item(it, 1'b0, '0);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending_hdrs.size() != 0);
  endtask

  task automatic run_header();
    php_pkg::in_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 24) == 0) wait_drained();
    it.header_start  = 1'b1;
    it.packet_length = pick_len();
    it.hdr_byte      = byte_for(ST_STUFF);
    send_item(it, 1'b0, '0);
    if (cur_phase == ST_STUFF && $urandom_range(0, 24) == 0) begin
      repeat ($urandom_range(10, 40)) send_data(php_pkg::STUFF_BYTE);
    end
    // drop out now and then so the next header start lands mid-parse
    while (cur_phase != ST_IDLE && $urandom_range(0, 99) != 0) send_data(byte_for(cur_phase));
  endtask

  task automatic cmp_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_header_result(php_pkg::out_item_t got);
    php_pkg::out_item_t want;
    if (pending_hdrs.size() == 0) begin
      $display("%0t: unexpected result expected none got %h", $time, got);
      errors++;
    end else begin
      want = pending_hdrs.pop_front();
      cmp_field("pts", want.pts, got.pts);
      cmp_field("pts_valid", want.pts_valid, got.pts_valid);
      cmp_field("dts", want.dts, got.dts);
      cmp_field("dts_valid", want.dts_valid, got.dts_valid);
      cmp_field("substream", want.substream, got.substream);
      cmp_field("payload_length", want.payload_length, got.payload_length);
      cmp_field("bad_header", want.bad_header, got.bad_header);
      cmp_field("is_mpeg2", want.is_mpeg2, got.is_mpeg2);
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    clear_parse();

    // idle byte
    add_row(8'h80, 1'b0, 16'd0, 1'b0, '0);
    // MPEG-2 forbidden timestamp code
    add_row(8'h80, 1'b1, 16'd100, 1'b0, '0);
    add_row(8'h40, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'h00, 1'b0, 16'd0, 1'b1, M2_BAD_RES);
    // MPEG-1 forbidden timestamp code, largest length
    add_row(8'h1F, 1'b1, 16'hFFFF, 1'b1, M1_BAD_RES);
    // MPEG-1 without timestamps, length underflow
    add_row(8'h00, 1'b1, 16'd0, 1'b1, M1_NONE_RES);
    // restart drops this header
    add_row(8'h85, 1'b1, 16'd7, 1'b0, '0);
    // short MPEG-2 header: both stamps flagged, length too small
    add_row(8'hFF, 1'b1, 16'd5, 1'b0, '0);
    add_row(8'h84, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'hC0, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'h02, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'h55, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'hAA, 1'b0, 16'd0, 1'b0, '0);
    // MPEG-1 with STD buffer, PTS all ones, DTS skipped
    add_row(8'h7F, 1'b1, 16'hFFFF, 1'b0, '0);
    add_row(8'h00, 1'b0, 16'd0, 1'b0, '0);
    add_row(8'h3F, 1'b0, 16'd0, 1'b0, '0);
    repeat (4) add_row(8'hFF, 1'b0, 16'd0, 1'b0, '0);
    repeat (5) add_row(8'h00, 1'b0, 16'd0, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();
    while (live_items < 900) run_header();
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = pick_gap(quiet_out);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      check_header_result(out_item);
      @(negedge clk);
    end
  end

  // switch between stretches with random gaps and back-to-back stretches
  initial begin : idle_mode
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> pes_header_parser_core.f
rtl/core/php_pkg.sv
rtl/core/php_front.sv
rtl/core/php_back.sv
rtl/core/pes_header_parser_core.sv
sim/tb_pes_header_parser_core.sv
